[sv/gmt_pkg.sv]
// Shared types and codes of the group membership table.
package gmt_pkg;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_LIST       = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NO_GROUP  = 3'd3,
      ST_FULL      = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_ENTRY     = 3'd6,
      ST_EMPTY     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_GSCAN,
      S_GPICK,
      S_MREAD,
      S_MCHECK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [9:0]  group_id;
      logic [31:0] member_addr;
      logic [15:0] member_port;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] entry_addr;
      logic [15:0] entry_port;
      logic [5:0]  member_total;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [15:0] port;
   } member_entry_type;

endpackage

[sv/gmt_member_mem.sv]
// Member slot memory: one write port, one registered read port.
module gmt_member_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  gmt_pkg::member_entry_type wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output gmt_pkg::member_entry_type rd_data
);

   gmt_pkg::member_entry_type mem [DEPTH];
   gmt_pkg::member_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/group_membership_table_top.sv]
// Top level of the group membership table: sequencer, group slots and result register.
// One request at a time. After reset a clearing pass writes every member memory slot
// and wipes the member memory before the first request is taken. A request then scans the
// group slots one per cycle and picks a slot, then reads every member slot of the group
// through the single memory read port, one read and one check per slot, and finishes
// with a result; the result side can stall the result and, for a list, the member reads.
// A request with no matching and no free group slot ends after the group scan.
// Operation code 3 is taken and dropped with no result.
module group_membership_table_top #(
   parameter int GROUP_SLOTS  = 16,
   parameter int MEMBER_SLOTS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gmt_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output gmt_pkg::rsp_payload_type rsp_payload
);

   localparam int DEPTH = GROUP_SLOTS * MEMBER_SLOTS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int GW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int MW = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
   localparam int CW = $clog2(MEMBER_SLOTS + 1);
   localparam logic [AW-1:0] MS_A = AW'(MEMBER_SLOTS);

   gmt_pkg::state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [9:0]  key_ff, key_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;
   logic [GW-1:0] gi_ff, gi_in, gidx_ff, gidx_in;
   logic [GW-1:0] gmatch_ff, gmatch_in, gfree_idx_ff, gfree_idx_in;
   logic gfound_ff, gfound_in, gfree_ff, gfree_in;
   logic [MW-1:0] mi_ff, mi_in, hit_idx_ff, hit_idx_in, mfree_idx_ff, mfree_idx_in;
   logic hit_ff, hit_in, mfree_ff, mfree_in;
   logic pend_ff, pend_in;
   logic [31:0] pend_addr_ff, pend_addr_in;
   logic [15:0] pend_port_ff, pend_port_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   gmt_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic          gvalid_ff [GROUP_SLOTS];
   logic          gvalid_in [GROUP_SLOTS];
   logic [9:0]    gkey_ff   [GROUP_SLOTS];
   logic [9:0]    gkey_in   [GROUP_SLOTS];
   logic [CW-1:0] gcount_ff [GROUP_SLOTS];
   logic [CW-1:0] gcount_in [GROUP_SLOTS];

   logic                      mem_we, mem_re;
   logic [AW-1:0]             mem_wa, mem_ra, base;
   gmt_pkg::member_entry_type mem_wd, mem_rd;

   logic                     out_free, load;
   gmt_pkg::rsp_payload_type rsp_next;
   logic [CW-1:0]            cur_count, new_count;
   logic                     advance;

   gmt_member_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur_count = gcount_ff[gidx_ff];
   assign base      = AW'(gidx_ff) * MS_A;
   assign req_ready = (state_ff == gmt_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      port_in      = port_ff;
      gi_in        = gi_ff;
      gidx_in      = gidx_ff;
      gmatch_in    = gmatch_ff;
      gfree_idx_in = gfree_idx_ff;
      gfound_in    = gfound_ff;
      gfree_in     = gfree_ff;
      mi_in        = mi_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      mfree_in     = mfree_ff;
      mfree_idx_in = mfree_idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pend_port_in = pend_port_ff;
      clr_in       = clr_ff;
      gvalid_in    = gvalid_ff;
      gkey_in      = gkey_ff;
      gcount_in    = gcount_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      mem_re       = 1'b0;
      mem_ra       = base + AW'(mi_ff);
      load         = 1'b0;
      rsp_next     = '0;
      new_count    = cur_count;
      advance      = 1'b1;

      unique case (state_ff)
         gmt_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = gmt_pkg::S_IDLE;
            end
         end
         gmt_pkg::S_IDLE: begin
            if (req_valid && (req_payload.operation != gmt_pkg::OP_NONE)) begin
               op_in     = req_payload.operation;
               key_in    = req_payload.group_id;
               addr_in   = req_payload.member_addr;
               port_in   = req_payload.member_port;
               gi_in     = '0;
               gfound_in = 1'b0;
               gfree_in  = 1'b0;
               state_in  = gmt_pkg::S_GSCAN;
            end
         end
         gmt_pkg::S_GSCAN: begin
            if (gvalid_ff[gi_ff] && (gkey_ff[gi_ff] == key_ff) && !gfound_ff) begin
               gfound_in = 1'b1;
               gmatch_in = gi_ff;
            end
            if (!gvalid_ff[gi_ff] && !gfree_ff) begin
               gfree_in     = 1'b1;
               gfree_idx_in = gi_ff;
            end
            if (gi_ff == GW'(GROUP_SLOTS - 1)) begin
               state_in = gmt_pkg::S_GPICK;
            end else begin
               gi_in = gi_ff + GW'(1);
            end
         end
         gmt_pkg::S_GPICK: begin
            mi_in    = '0;
            hit_in   = 1'b0;
            mfree_in = 1'b0;
            pend_in  = 1'b0;
            if (gfound_ff) begin
               gidx_in  = gmatch_ff;
               state_in = gmt_pkg::S_MREAD;
            end else if (gfree_ff) begin
               // allocate the lowest free slot for this key
               gidx_in                 = gfree_idx_ff;
               gvalid_in[gfree_idx_ff] = 1'b1;
               gkey_in[gfree_idx_ff]   = key_ff;
               gcount_in[gfree_idx_ff] = '0;
               state_in                = gmt_pkg::S_MREAD;
            end else if (out_free) begin
               load            = 1'b1;
               rsp_next.status = gmt_pkg::ST_NO_GROUP;
               rsp_next.last   = 1'b1;
               state_in        = gmt_pkg::S_IDLE;
            end
         end
         gmt_pkg::S_MREAD: begin
            mem_re   = 1'b1;
            state_in = gmt_pkg::S_MCHECK;
         end
         gmt_pkg::S_MCHECK: begin
            if (op_ff == gmt_pkg::OP_LIST) begin
               if (mem_rd.valid) begin
                  // hold one entry back so the final one can carry last
                  if (pend_ff && !out_free) begin
                     advance = 1'b0;
                  end else begin
                     if (pend_ff) begin
                        load                  = 1'b1;
                        rsp_next.status       = gmt_pkg::ST_ENTRY;
                        rsp_next.entry_addr   = pend_addr_ff;
                        rsp_next.entry_port   = pend_port_ff;
                        rsp_next.member_total = 6'(cur_count);
                     end
                     pend_in      = 1'b1;
                     pend_addr_in = mem_rd.addr;
                     pend_port_in = mem_rd.port;
                  end
               end
            end else begin
               if (mem_rd.valid && (mem_rd.addr == addr_ff) && (mem_rd.port == port_ff)
                   && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = mi_ff;
               end
               if (!mem_rd.valid && !mfree_ff) begin
                  mfree_in     = 1'b1;
                  mfree_idx_in = mi_ff;
               end
            end
            if (advance) begin
               if (mi_ff == MW'(MEMBER_SLOTS - 1)) begin
                  state_in = gmt_pkg::S_FINISH;
               end else begin
                  mi_in    = mi_ff + MW'(1);
                  state_in = gmt_pkg::S_MREAD;
               end
            end
         end
         gmt_pkg::S_FINISH: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_next.last = 1'b1;
               state_in      = gmt_pkg::S_IDLE;
               priority case (op_ff)
                  gmt_pkg::OP_REGISTER: begin
                     if (cur_count >= CW'(MEMBER_SLOTS)) begin
                        rsp_next.status = gmt_pkg::ST_FULL;
                     end else if (hit_ff) begin
                        rsp_next.status = gmt_pkg::ST_PRESENT;
                     end else if (mfree_ff) begin
                        new_count          = cur_count + CW'(1);
                        gcount_in[gidx_ff] = new_count;
                        mem_we             = 1'b1;
                        mem_wa             = base + AW'(mfree_idx_ff);
                        mem_wd.valid       = 1'b1;
                        mem_wd.addr        = addr_ff;
                        mem_wd.port        = port_ff;
                        rsp_next.status    = gmt_pkg::ST_ADDED;
                     end else begin
                        rsp_next.status = gmt_pkg::ST_FULL;
                     end
                     rsp_next.member_total = 6'(new_count);
                  end
                  gmt_pkg::OP_UNREGISTER: begin
                     if (hit_ff) begin
                        if (cur_count != '0) begin
                           new_count = cur_count - CW'(1);
                        end
                        gcount_in[gidx_ff] = new_count;
                        if (new_count == '0) begin
                           gvalid_in[gidx_ff] = 1'b0;
                        end
                        mem_we          = 1'b1;
                        mem_wa          = base + AW'(hit_idx_ff);
                        rsp_next.status = gmt_pkg::ST_REMOVED;
                     end else begin
                        rsp_next.status = gmt_pkg::ST_NOT_FOUND;
                     end
                     rsp_next.member_total = 6'(new_count);
                  end
                  default: begin
                     if (pend_ff) begin
                        rsp_next.status       = gmt_pkg::ST_ENTRY;
                        rsp_next.entry_addr   = pend_addr_ff;
                        rsp_next.entry_port   = pend_port_ff;
                        rsp_next.member_total = 6'(cur_count);
                     end else begin
                        rsp_next.status = gmt_pkg::ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = gmt_pkg::S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_next;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmt_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUP_SLOTS; g++) begin
            gvalid_ff[g] <= 1'b0;
            gcount_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         gvalid_ff    <= gvalid_in;
         gcount_ff    <= gcount_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      addr_ff      <= addr_in;
      port_ff      <= port_in;
      gi_ff        <= gi_in;
      gidx_ff      <= gidx_in;
      gmatch_ff    <= gmatch_in;
      gfree_idx_ff <= gfree_idx_in;
      gfound_ff    <= gfound_in;
      gfree_ff     <= gfree_in;
      mi_ff        <= mi_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      mfree_ff     <= mfree_in;
      mfree_idx_ff <= mfree_idx_in;
      pend_ff      <= pend_in;
      pend_addr_ff <= pend_addr_in;
      pend_port_ff <= pend_port_in;
      gkey_ff      <= gkey_in;
      rsp_ff       <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded over an unaccepted one");

   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_payload.operation != gmt_pkg::OP_NONE))
      |=> (state_ff == gmt_pkg::S_GSCAN) && (gi_ff == '0))
      else $error("accepted item did not start a group scan");

   a_free_group_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmt_pkg::S_GSCAN) && !gvalid_ff[gi_ff] |-> (gcount_ff[gi_ff] == '0))
      else $error("free group slot holds a nonzero count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmt_pkg::S_MREAD) |-> (cur_count <= CW'(MEMBER_SLOTS)))
      else $error("group count above member slots");
`endif

endmodule

[tb/sv/group_membership_table_top_tb.sv]
// Testbench of the group membership table: table-driven directed items, random items, scoreboard.
`timescale 1ns / 1ps

module group_membership_table_top_tb;

   localparam int GROUPS  = 16;
   localparam int MEMBERS = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = GROUPS + 2 * MEMBERS + 8;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   gmt_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   gmt_pkg::rsp_payload_type rsp_payload;

   group_membership_table_top #(
      .GROUP_SLOTS(GROUPS),
      .MEMBER_SLOTS(MEMBERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // shadow copy of the table
   logic        grp_used [GROUPS];
   logic [9:0]  grp_id   [GROUPS];
   int          grp_size [GROUPS];
   logic        mem_used [GROUPS][MEMBERS];
   logic [31:0] mem_addr [GROUPS][MEMBERS];
   logic [15:0] mem_port [GROUPS][MEMBERS];

   gmt_pkg::rsp_payload_type expected_rsps[$];
   int  error_count;
   int  rsp_count;
   int  idle_cycles;
   int  hold_off;
   int  status_seen [8];
   int  last_made;
   gmt_pkg::rsp_payload_type last_tail;

   typedef struct {
      gmt_pkg::op_type     op;
      logic [9:0]          gid;
      logic [31:0]         addr;
      logic [15:0]         port;
      bit                  typed;
      gmt_pkg::status_type want_status;
      logic [5:0]          want_total;
   } stim_row_type;

   stim_row_type plan[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic gmt_pkg::rsp_payload_type make_rsp(gmt_pkg::status_type st,
                                                         logic [31:0] addr,
                                                         logic [15:0] port, int total,
                                                         logic last);
      gmt_pkg::rsp_payload_type r;
      r.status = st;
      r.entry_addr = addr;
      r.entry_port = port;
      r.member_total = total[5:0];
      r.last = last;
      return r;
   endfunction

   // find the group or take the lowest free slot; -1 when none is free
   function automatic int claim_group(logic [9:0] gid);
      for (int g = 0; g < GROUPS; g++)
         if (grp_used[g] && grp_id[g] == gid) return g;
      for (int g = 0; g < GROUPS; g++) begin
         if (!grp_used[g]) begin
            grp_used[g] = 1'b1;
            grp_id[g] = gid;
            grp_size[g] = 0;
            return g;
         end
      end
      return -1;
   endfunction

   function automatic int find_slot(int g, logic [31:0] addr, logic [15:0] port);
      for (int m = 0; m < MEMBERS; m++)
         if (mem_used[g][m] && mem_addr[g][m] == addr && mem_port[g][m] == port) return m;
      return -1;
   endfunction

   task automatic predict_membership(input gmt_pkg::req_payload_type item);
      int g;
      int m;
      int n;
      if (item.operation == gmt_pkg::OP_NONE) return;
      g = claim_group(item.group_id);
      if (g < 0) begin
         expected_rsps.push_back(make_rsp(gmt_pkg::ST_NO_GROUP, 0, 0, 0, 1'b1));
         return;
      end
      case (item.operation)
         gmt_pkg::OP_REGISTER: begin
            if (grp_size[g] >= MEMBERS) begin
               expected_rsps.push_back(make_rsp(gmt_pkg::ST_FULL, 0, 0, grp_size[g], 1'b1));
            end else if (find_slot(g, item.member_addr, item.member_port) >= 0) begin
               expected_rsps.push_back(make_rsp(gmt_pkg::ST_PRESENT, 0, 0, grp_size[g],
                                                1'b1));
            end else begin
               m = -1;
               for (int k = 0; k < MEMBERS && m < 0; k++)
                  if (!mem_used[g][k]) m = k;
               if (m < 0) begin
                  expected_rsps.push_back(make_rsp(gmt_pkg::ST_FULL, 0, 0, grp_size[g],
                                                   1'b1));
               end else begin
                  mem_used[g][m] = 1'b1;
                  mem_addr[g][m] = item.member_addr;
                  mem_port[g][m] = item.member_port;
                  grp_size[g]++;
                  expected_rsps.push_back(make_rsp(gmt_pkg::ST_ADDED, 0, 0, grp_size[g],
                                                   1'b1));
               end
            end
         end
         gmt_pkg::OP_UNREGISTER: begin
            m = find_slot(g, item.member_addr, item.member_port);
            if (m < 0) begin
               expected_rsps.push_back(make_rsp(gmt_pkg::ST_NOT_FOUND, 0, 0, grp_size[g],
                                                1'b1));
            end else begin
               mem_used[g][m] = 1'b0;
               if (grp_size[g] > 0) grp_size[g]--;
               if (grp_size[g] == 0) grp_used[g] = 1'b0;
               expected_rsps.push_back(make_rsp(gmt_pkg::ST_REMOVED, 0, 0, grp_size[g],
                                                1'b1));
            end
         end
         default: begin
            n = 0;
            for (int k = 0; k < MEMBERS; k++)
               if (mem_used[g][k]) n++;
            if (n == 0) begin
               expected_rsps.push_back(make_rsp(gmt_pkg::ST_EMPTY, 0, 0, 0, 1'b1));
            end else begin
               for (int k = 0; k < MEMBERS; k++) begin
                  if (mem_used[g][k]) begin
                     n--;
                     expected_rsps.push_back(make_rsp(gmt_pkg::ST_ENTRY, mem_addr[g][k],
                        mem_port[g][k], grp_size[g], n == 0));
                  end
               end
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input gmt_pkg::req_payload_type item);
      int queued_before;
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queued_before = expected_rsps.size();
      predict_membership(item);
      last_made = expected_rsps.size() - queued_before;
      if (last_made > 0) last_tail = expected_rsps[$];
      @(negedge clock);
      req_valid <= 1'b0;
      // the block is busy right after accepting an operation other than code 3, so a one-cycle drop costs nothing there
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   function automatic void add_row(gmt_pkg::op_type op, logic [9:0] gid, logic [31:0] addr,
                                   logic [15:0] port, bit typed = 0,
                                   gmt_pkg::status_type st = gmt_pkg::ST_ADDED,
                                   int total = 0);
      stim_row_type r;
      r.op = op; r.gid = gid; r.addr = addr; r.port = port;
      r.typed = typed; r.want_status = st; r.want_total = total[5:0];
      plan.push_back(r);
   endfunction

   // random item biased toward a few groups and a small pool of members
   function automatic gmt_pkg::req_payload_type random_item(int phase);
      gmt_pkg::req_payload_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) it.operation = gmt_pkg::OP_REGISTER;
      else if (r < 75) it.operation = gmt_pkg::OP_UNREGISTER;
      else if (r < 95) it.operation = gmt_pkg::OP_LIST;
      else it.operation = gmt_pkg::OP_NONE;
      if ($urandom_range(0, 9) < 8) it.group_id = 10'($urandom_range(0, 5) * 167);
      else it.group_id = 10'($urandom_range(0, 1023));
      if (phase == 1) it.group_id = 10'($urandom_range(600, 630));
      if ($urandom_range(0, 9) < 7) begin
         it.member_addr = {$urandom_range(0, 1) ? 8'hff : 8'h0a, 16'h0, 8'($urandom_range(0, 39))};
         it.member_port = {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom_range(0, 3))};
      end else begin
         it.member_addr = $urandom;
         it.member_port = 16'($urandom);
      end
      return it;
   endfunction

   // result side: random stalls, plus one long hold-off while the sender keeps going
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      gmt_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         status_seen[rsp_payload.status]++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected item, status", rsp_payload.status, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.entry_addr !== want.entry_addr)
               report_mismatch("entry_addr", rsp_payload.entry_addr, want.entry_addr);
            if (rsp_payload.entry_port !== want.entry_port)
               report_mismatch("entry_port", rsp_payload.entry_port, want.entry_port);
            if (rsp_payload.member_total !== want.member_total)
               report_mismatch("member_total", rsp_payload.member_total, want.member_total);
            if (rsp_payload.last !== want.last)
               report_mismatch("last", rsp_payload.last, want.last);
         end
      end
   end

   // watchdog: count cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || !req_valid && expected_rsps.size() == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d items outstanding", expected_rsps.size());
         $display("group_membership_table_top_tb failed");
         $finish;
      end
   end

   initial begin
      gmt_pkg::req_payload_type it;
      error_count = 0;
      rsp_count = 0;
      hold_off = 0;
      last_made = 0;
      req_valid = 1'b0;
      req_payload = '0;
      reset = 1'b1;
      for (int g = 0; g < GROUPS; g++) begin
         grp_used[g] = 1'b0;
         grp_size[g] = 0;
         for (int m = 0; m < MEMBERS; m++) mem_used[g][m] = 1'b0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table
      add_row(gmt_pkg::OP_LIST, 10'd0, 0, 0, 1, gmt_pkg::ST_EMPTY, 0);
      add_row(gmt_pkg::OP_UNREGISTER, 10'd1023, 32'hffffffff, 16'hffff, 1,
              gmt_pkg::ST_NOT_FOUND, 0);
      add_row(gmt_pkg::OP_REGISTER, 10'd1023, 32'hffffffff, 16'hffff, 1,
              gmt_pkg::ST_ADDED, 1);
      add_row(gmt_pkg::OP_REGISTER, 10'd1023, 32'hffffffff, 16'hffff, 1,
              gmt_pkg::ST_PRESENT, 1);
      add_row(gmt_pkg::OP_REGISTER, 10'd1023, 32'h0, 16'h0, 1, gmt_pkg::ST_ADDED, 2);
      add_row(gmt_pkg::OP_NONE, 10'd1023, 32'h12345678, 16'h1);
      add_row(gmt_pkg::OP_LIST, 10'd1023, 32'h5a5a5a5a, 16'ha5a5);
      add_row(gmt_pkg::OP_UNREGISTER, 10'd1023, 32'hffffffff, 16'hffff, 1,
              gmt_pkg::ST_REMOVED, 1);
      add_row(gmt_pkg::OP_UNREGISTER, 10'd1023, 32'h0, 16'h0, 1, gmt_pkg::ST_REMOVED, 0);
      add_row(gmt_pkg::OP_LIST, 10'd1023, 0, 0, 1, gmt_pkg::ST_EMPTY, 0);
      // exhaust the group slots: lists of new ids keep their slots
      for (int k = 0; k < GROUPS - 1; k++) add_row(gmt_pkg::OP_LIST, 10'(k + 1), 0, 0);
      add_row(gmt_pkg::OP_REGISTER, 10'd999, 32'h1, 16'h1, 1, gmt_pkg::ST_NO_GROUP, 0);
      add_row(gmt_pkg::OP_LIST, 10'd1023, 0, 0, 1, gmt_pkg::ST_EMPTY, 0);
      add_row(gmt_pkg::OP_REGISTER, 10'd512, 32'h80000000, 16'h8000);
      foreach (plan[i]) begin
         it.operation = plan[i].op;
         it.group_id = plan[i].gid;
         it.member_addr = plan[i].addr;
         it.member_port = plan[i].port;
         send_item(it);
         if (plan[i].typed) begin
            if (last_made != 1 || last_tail.status != plan[i].want_status
                || last_tail.member_total != plan[i].want_total)
               report_mismatch("table row status", last_tail.status,
                               plan[i].want_status);
         end
         if (pick_gap() > 5) repeat ($urandom_range(1, 20)) @(negedge clock);
      end

      // free the exhausted slots by registering then unregistering in each
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      reset <= 1'b0;
      for (int k = 1; k < GROUPS; k++) begin
         it = '{gmt_pkg::OP_REGISTER, 10'(k), 32'(k), 16'(k)};
         send_item(it);
         it.operation = gmt_pkg::OP_UNREGISTER;
         send_item(it);
      end
      for (int k = 0; k < 2; k++) begin
         it = '{gmt_pkg::OP_UNREGISTER, 10'd1023, 32'h0, 16'h0};
         send_item(it);
      end

      // fill one group past capacity, with a long result stall under way
      hold_off = 400;
      for (int k = 0; k < MEMBERS + 3; k++) begin
         it = '{gmt_pkg::OP_REGISTER, 10'd777, 32'(k * 32'h01010101), 16'(k)};
         send_item(it);
      end
      it = '{gmt_pkg::OP_REGISTER, 10'd777, 32'h0, 16'h0};
      send_item(it);
      it = '{gmt_pkg::OP_LIST, 10'd777, 32'h0, 16'h0};
      send_item(it);
      for (int k = 0; k < MEMBERS; k += 2) begin
         it = '{gmt_pkg::OP_UNREGISTER, 10'd777, 32'(k * 32'h01010101), 16'(k)};
         send_item(it);
      end
      it = '{gmt_pkg::OP_LIST, 10'd777, 32'h0, 16'h0};
      send_item(it);

      // pause until everything has come back
      wait_drained();

      for (int i = 0; i < 240; i++) begin
         send_item(random_item(i % 50 > 45));
         if (i % 20 == 0) repeat (pick_gap()) @(negedge clock);
         else if ($urandom_range(0, 2) == 0) repeat (pick_gap()) @(negedge clock);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("checked %0d result items: added %0d, present %0d, removed %0d, no slot %0d,",
               rsp_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("  full %0d, not found %0d, list entries %0d, empty lists %0d",
               status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("group_membership_table_top_tb passed");
      end else begin
         $display("%0d mismatches, %0d items left over", error_count, expected_rsps.size());
         $display("group_membership_table_top_tb failed");
      end
      $finish;
   end

endmodule
